// ===== hdl/amce_pkg.sv =====
// shared types, constants and tables for the multichannel adpcm encoder
`timescale 1ns / 1ps

package amce_pkg;

    // field widths
    localparam int SAMPLE_W   = 12;
    localparam int CHAN_W     = 3;
    localparam int INDEX_W    = 6;
    localparam int STEP_W     = 11;
    localparam int CODE_W     = 4;
    localparam int CMD_W      = 1;

    // stream bus widths (fields packed from bit 0, padded to bytes)
    localparam int S_DATA_W   = 16;
    localparam int M_DATA_W   = 8;

    // configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 2;

    // limits and reset values
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX   = 12'hFFF;
    localparam logic [INDEX_W-1:0]  INDEX_MAX    = 6'd48;
    localparam logic [SAMPLE_W-1:0] REST_DEFAULT = 12'h800;
    localparam int                  CHANNELS_DEF = 8;
    localparam int                  CHANNELS_MAX = 8;

    // register word indexes
    localparam logic [APB_ADDR_W-1:0] REG_REST_LEVEL = 2'd0;

    // item commands
    typedef enum logic [CMD_W-1:0] {
        CMD_ENCODE = 1'b0,
        CMD_RESET  = 1'b1
    } t_cmd;

    // per-channel predictor state
    typedef struct packed {
        logic [SAMPLE_W-1:0] pred;
        logic [INDEX_W-1:0]  idx;
    } t_chan_state;

    // step size table, saturating at the last entry
    function automatic logic [STEP_W-1:0] step_size(input logic [INDEX_W-1:0] idx);
        logic [STEP_W-1:0] s;
        begin
            case (idx)
                6'd0:  s = 11'd16;    6'd1:  s = 11'd17;    6'd2:  s = 11'd19;
                6'd3:  s = 11'd21;    6'd4:  s = 11'd23;    6'd5:  s = 11'd25;
                6'd6:  s = 11'd28;    6'd7:  s = 11'd31;    6'd8:  s = 11'd34;
                6'd9:  s = 11'd37;    6'd10: s = 11'd41;    6'd11: s = 11'd45;
                6'd12: s = 11'd50;    6'd13: s = 11'd55;    6'd14: s = 11'd60;
                6'd15: s = 11'd66;    6'd16: s = 11'd73;    6'd17: s = 11'd80;
                6'd18: s = 11'd88;    6'd19: s = 11'd97;    6'd20: s = 11'd107;
                6'd21: s = 11'd118;   6'd22: s = 11'd130;   6'd23: s = 11'd143;
                6'd24: s = 11'd157;   6'd25: s = 11'd173;   6'd26: s = 11'd190;
                6'd27: s = 11'd209;   6'd28: s = 11'd230;   6'd29: s = 11'd253;
                6'd30: s = 11'd279;   6'd31: s = 11'd307;   6'd32: s = 11'd337;
                6'd33: s = 11'd371;   6'd34: s = 11'd408;   6'd35: s = 11'd449;
                6'd36: s = 11'd494;   6'd37: s = 11'd544;   6'd38: s = 11'd598;
                6'd39: s = 11'd658;   6'd40: s = 11'd724;   6'd41: s = 11'd796;
                6'd42: s = 11'd876;   6'd43: s = 11'd963;   6'd44: s = 11'd1060;
                6'd45: s = 11'd1166;  6'd46: s = 11'd1282;  6'd47: s = 11'd1411;
                default: s = 11'd1552;
            endcase
            return s;
        end
    endfunction

    // step index adjustment by code magnitude
    function automatic logic signed [4:0] index_adjust(input logic [2:0] mag);
        logic signed [4:0] a;
        begin
            case (mag)
                3'd4:    a = 5'sd2;
                3'd5:    a = 5'sd4;
                3'd6:    a = 5'sd6;
                3'd7:    a = 5'sd8;
                default: a = -5'sd1;
            endcase
            return a;
        end
    endfunction

endpackage

// ===== hdl/amce_apb_regs.sv =====
// apb configuration register block holding the rest level
`timescale 1ns / 1ps

module amce_apb_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [amce_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [amce_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [amce_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output logic [amce_pkg::SAMPLE_W-1:0]      o_rest_level
);
    import amce_pkg::*;

    logic [SAMPLE_W-1:0] r_rest_level;
    logic                w_wr;

    // write strobe on the access phase
    assign w_wr   = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    // rest level register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rest_level <= REST_DEFAULT;
        end else if (w_wr && (paddr == REG_REST_LEVEL)) begin
            r_rest_level <= pwdata[SAMPLE_W-1:0];
        end
    end

    // read mux
    always_comb begin
        prdata = '0;
        case (paddr)
            REG_REST_LEVEL: prdata = {{(APB_DATA_W-SAMPLE_W){1'b0}}, r_rest_level};
            default:        prdata = '0;
        endcase
    end

    assign o_rest_level = r_rest_level;

endmodule

// ===== hdl/amce_quant.sv =====
// one-pass adpcm quantizer and predictor/step index update for one sample
`timescale 1ns / 1ps

module amce_quant (
    input  logic [amce_pkg::SAMPLE_W-1:0] i_sample,
    input  amce_pkg::t_chan_state         i_state,
    output logic [amce_pkg::CODE_W-1:0]   o_code,
    output amce_pkg::t_chan_state         o_next
);
    import amce_pkg::*;

    logic [INDEX_W-1:0]        w_idx;
    logic [STEP_W-1:0]         w_step;
    logic signed [SAMPLE_W:0]  w_diff;
    logic                      w_neg;
    logic [SAMPLE_W-1:0]       w_mag0;
    logic [SAMPLE_W-1:0]       w_mag1;
    logic [SAMPLE_W-1:0]       w_mag2;
    logic                      w_b2;
    logic                      w_b1;
    logic                      w_b0;
    logic [SAMPLE_W-1:0]       w_delta;
    logic signed [SAMPLE_W+1:0] w_pred_sum;
    logic signed [7:0]         w_idx_sum;

    // saturate the index and look up the step
    assign w_idx  = (i_state.idx > INDEX_MAX) ? INDEX_MAX : i_state.idx;
    assign w_step = step_size(w_idx);

    // signed difference and its magnitude
    assign w_diff = $signed({1'b0, i_sample}) - $signed({1'b0, i_state.pred});
    assign w_neg  = w_diff[SAMPLE_W];
    assign w_mag0 = w_neg ? SAMPLE_W'(-w_diff) : w_diff[SAMPLE_W-1:0];

    // three compare-subtract stages against step, step/2, step/4
    assign w_b2   = w_mag0 >= {1'b0, w_step};
    assign w_mag1 = w_b2 ? (w_mag0 - {1'b0, w_step}) : w_mag0;
    assign w_b1   = w_mag1 >= {2'b0, w_step[STEP_W-1:1]};
    assign w_mag2 = w_b1 ? (w_mag1 - {2'b0, w_step[STEP_W-1:1]}) : w_mag1;
    assign w_b0   = w_mag2 >= {3'b0, w_step[STEP_W-1:2]};

    // rebuilt difference
    assign w_delta = {4'b0, w_step[STEP_W-1:3]}
                   + (w_b2 ? {1'b0, w_step} : '0)
                   + (w_b1 ? {2'b0, w_step[STEP_W-1:1]} : '0)
                   + (w_b0 ? {3'b0, w_step[STEP_W-1:2]} : '0);

    assign o_code = {w_neg, w_b2, w_b1, w_b0};

    // predictor sum before the clamp
    assign w_pred_sum = w_neg
        ? ($signed({2'b0, i_state.pred}) - $signed({2'b0, w_delta}))
        : ($signed({2'b0, i_state.pred}) + $signed({2'b0, w_delta}));

    // step index sum before the clamp
    assign w_idx_sum = $signed({2'b0, w_idx}) + 8'(index_adjust({w_b2, w_b1, w_b0}));

    // clamp predictor to the sample range and step index to 0..48
    always_comb begin
        if (w_pred_sum < 0) begin
            o_next.pred = '0;
        end else if (w_pred_sum > $signed({2'b0, SAMPLE_MAX})) begin
            o_next.pred = SAMPLE_MAX;
        end else begin
            o_next.pred = w_pred_sum[SAMPLE_W-1:0];
        end
        if (w_idx_sum < 0) begin
            o_next.idx = '0;
        end else if (w_idx_sum > $signed({2'b0, INDEX_MAX})) begin
            o_next.idx = INDEX_MAX;
        end else begin
            o_next.idx = w_idx_sum[INDEX_W-1:0];
        end
    end

endmodule

// ===== hdl/adpcm_multichannel_encoder.sv =====
// Multichannel 4-bit ADPCM encoder: input register, combinational quantizer, result register.
// The code of a beat is computed from the input register and held in the result register,
// which holds while m_axis_tready is low. Throughput: one beat per cycle when not stalled;
// channel state is written as an item leaves the input register, so back-to-back beats on
// the same channel see the updated state.
// Reset (synchronous, active low) empties both pipeline registers, sets every
// channel to predictor 2048 and step index 0, and rest_level to 2048.
`timescale 1ns / 1ps

module adpcm_multichannel_encoder #(
    parameter int CHANNELS = amce_pkg::CHANNELS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // stream in
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [amce_pkg::S_DATA_W-1:0]      s_axis_tdata,  // [2:0] channel, [14:3] sample
    input  logic                               s_axis_tuser,  // [0] command
    // stream out
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [amce_pkg::M_DATA_W-1:0]      m_axis_tdata,  // [3:0] code
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [amce_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [amce_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [amce_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import amce_pkg::*;

    localparam int              CH_IW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CHAN_W:0] CH_LIMIT = (CHAN_W+1)'(CHANNELS);

    logic [SAMPLE_W-1:0] w_rest_level;

    logic                r_in_valid;
    t_cmd                r_in_cmd;
    logic [CHAN_W-1:0]   r_in_ch;
    logic [SAMPLE_W-1:0] r_in_sample;

    logic                r_out_valid;
    logic [CODE_W-1:0]   r_code;
    logic [CODE_W-1:0]   n_code;

    t_chan_state         r_state [CHANNELS];
    t_chan_state         w_cur;
    t_chan_state         w_next;
    logic [CODE_W-1:0]   w_q_code;

    logic                w_advance;
    logic                w_s_take;
    logic                w_ch_ok;
    logic [CH_IW-1:0]    w_ch_idx;

    // configuration registers
    amce_apb_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_rest_level (w_rest_level)
    );

    // handshake: the result register frees when taken, the input register when it moves on
    assign w_advance     = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_s_take      = s_axis_tvalid && s_axis_tready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_s_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_take) begin
            r_in_cmd    <= t_cmd'(s_axis_tuser);
            r_in_ch     <= s_axis_tdata[CHAN_W-1:0];
            r_in_sample <= s_axis_tdata[CHAN_W +: SAMPLE_W];
        end
    end

    // channel select
    assign w_ch_ok  = {1'b0, r_in_ch} < CH_LIMIT;
    assign w_ch_idx = r_in_ch[CH_IW-1:0];
    assign w_cur    = w_ch_ok ? r_state[w_ch_idx]
                              : t_chan_state'{pred: REST_DEFAULT, idx: '0};

    // quantizer
    amce_quant u_quant (
        .i_sample (r_in_sample),
        .i_state  (w_cur),
        .o_code   (w_q_code),
        .o_next   (w_next)
    );

    // code for this item: zero on reset command or unknown channel
    always_comb begin
        n_code = '0;
        if (w_ch_ok && (r_in_cmd == CMD_ENCODE)) begin
            n_code = w_q_code;
        end
    end

    // per-channel state, written as the item moves to the result register
    for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_state[g] <= '{pred: REST_DEFAULT, idx: '0};
            end else if (r_in_valid && w_advance && w_ch_ok && (w_ch_idx == CH_IW'(g))) begin
                if (r_in_cmd == CMD_RESET) begin
                    r_state[g] <= '{pred: w_rest_level, idx: '0};
                end else begin
                    r_state[g] <= w_next;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_valid) begin
            r_code <= n_code;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_DATA_W-CODE_W){1'b0}}, r_code};

endmodule
